@@ hw/rtl/smie_pkg.sv @@
`timescale 1ns / 1ps
package smie_pkg;

   // Instruction op codes.
   typedef enum logic [3:0] {
      OP_NOP    = 4'd0,
      OP_ILL    = 4'd1,
      OP_LOAD   = 4'd2,
      OP_STORE  = 4'd3,
      OP_ADD    = 4'd4,
      OP_SUB    = 4'd5,
      OP_BRANCH = 4'd6,
      OP_CALL   = 4'd7,
      OP_RET    = 4'd8,
      OP_PUSH   = 4'd9,
      OP_POP    = 4'd10,
      OP_HALT   = 4'd11,
      OP_HWR    = 4'd12,
      OP_HRD    = 4'd13,
      OP_UNK14  = 4'd14,
      OP_UNK15  = 4'd15
   } op_type;

   // Error codes.
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_ILL   = 3'd1;
   localparam logic [2:0] ERR_UNK   = 3'd2;
   localparam logic [2:0] ERR_IMM   = 3'd3;
   localparam logic [2:0] ERR_DATA  = 3'd4;
   localparam logic [2:0] ERR_STACK = 3'd5;
   localparam logic [2:0] ERR_COND  = 3'd6;

   // Condition codes.
   localparam logic [1:0] CC_NEG  = 2'd0;
   localparam logic [1:0] CC_ZERO = 2'd1;
   localparam logic [1:0] CC_POS  = 2'd2;

   // Branch conditions.
   localparam logic [3:0] BC_ALWAYS = 4'd0;
   localparam logic [3:0] BC_EQ     = 4'd1;
   localparam logic [3:0] BC_NE     = 4'd2;
   localparam logic [3:0] BC_GT     = 4'd3;
   localparam logic [3:0] BC_GE     = 4'd4;
   localparam logic [3:0] BC_LT     = 4'd5;
   localparam logic [3:0] BC_LE     = 4'd6;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_STACK_LOW  = 2'd0;
   localparam logic [1:0] CSR_DATA_LIMIT = 2'd1;
   localparam logic [1:0] CSR_SP_START   = 2'd2;
   localparam logic [1:0] CSR_PC_START   = 2'd3;

   // Memory request from the control stage to the data memory.
   typedef struct packed {
      logic        rd_en;
      logic [19:0] rd_addr;
      logic        wr_en;
      logic [19:0] wr_addr;
      logic [31:0] wr_data;
   } mem_req_type;

endpackage

@@ hw/rtl/stack_machine_instruction_execute.sv @@
`timescale 1ns / 1ps
// Items without a memory read go straight to the result register; items with one pass stage 1 first.
// Throughput: one item per cycle without a read while the result register is free; an item with a data read
// (load, add, sub from memory, push from memory, pop, ret, host read) holds the input for its read and then
// its retire and write back on the single data-memory port.
// Reset: synchronous, clears registers, PC to 0, SP to 4095, code to zero, run state.
module stack_machine_instruction_execute #(
   parameter int DATA_WORDS = 4096,
   parameter int NUM_REGS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_op,
   input  logic        req_imm_mode,
   input  logic        req_indexed_mode,
   input  logic [3:0]  req_reg_or_cond,
   input  logic [3:0]  req_index_reg,
   input  logic signed [15:0] req_offset,
   input  logic [19:0] req_abs_address,
   input  logic signed [19:0] req_imm_value,
   input  logic signed [31:0] req_host_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_next_pc,
   output logic signed [31:0] rsp_result_word,
   output logic [1:0]  rsp_cond_code,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_stopped,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import smie_pkg::*;

   logic [12:0] stack_low_ff, data_limit_ff;
   logic [11:0] sp_start_ff;
   logic [19:0] pc_start_ff;
   logic        wr, sp_load, pc_load;
   logic [1:0]  idx;
   mem_req_type mem_req;
   logic [31:0] mem_rd_data;

   assign pready  = 1'b1;
   assign idx     = paddr[3:2];
   assign wr      = psel && penable && pwrite;
   assign sp_load = wr && idx == CSR_SP_START;
   assign pc_load = wr && idx == CSR_PC_START;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_low_ff  <= 13'd0;
         data_limit_ff <= 13'd4096;
         sp_start_ff   <= 12'd4095;
         pc_start_ff   <= 20'd0;
      end else if (wr) begin
         case (idx)
            CSR_STACK_LOW:  stack_low_ff  <= pwdata[12:0];
            CSR_DATA_LIMIT: data_limit_ff <= pwdata[12:0];
            CSR_SP_START:   sp_start_ff   <= pwdata[11:0];
            CSR_PC_START:   pc_start_ff   <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_STACK_LOW:  prdata = {19'd0, stack_low_ff};
         CSR_DATA_LIMIT: prdata = {19'd0, data_limit_ff};
         CSR_SP_START:   prdata = {20'd0, sp_start_ff};
         CSR_PC_START:   prdata = {12'd0, pc_start_ff};
         default:        prdata = '0;
      endcase
   end

   smie_core #(.DATA_WORDS(DATA_WORDS), .NUM_REGS(NUM_REGS)) u_core (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_imm_mode,
      .req_indexed_mode, .req_reg_or_cond, .req_index_reg, .req_offset,
      .req_abs_address, .req_imm_value, .req_host_word, .rsp_valid, .rsp_ready,
      .rsp_next_pc, .rsp_result_word, .rsp_cond_code, .rsp_error_code, .rsp_stopped,
      .stack_low(stack_low_ff), .data_limit(data_limit_ff),
      .sp_load, .sp_value(pwdata[11:0]), .pc_load, .pc_value(pwdata[19:0]),
      .mem_req, .mem_rd_data
   );

   smie_data_ram #(.DATA_WORDS(DATA_WORDS)) u_ram (
      .clock, .req(mem_req), .rd_data(mem_rd_data)
   );
endmodule

@@ hw/rtl/smie_data_ram.sv @@
`timescale 1ns / 1ps
module smie_data_ram #(
   parameter int DATA_WORDS = 4096
) (
   input  logic                    clock,
   input  smie_pkg::mem_req_type   req,
   output logic [31:0]             rd_data
);
   import smie_pkg::*;

   localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

   logic [31:0] mem [DATA_WORDS];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr[AW-1:0]] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr[AW-1:0]];
      end
   end
endmodule

@@ hw/rtl/smie_core.sv @@
`timescale 1ns / 1ps
module smie_core #(
   parameter int DATA_WORDS = 4096,
   parameter int NUM_REGS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_op,
   input  logic        req_imm_mode,
   input  logic        req_indexed_mode,
   input  logic [3:0]  req_reg_or_cond,
   input  logic [3:0]  req_index_reg,
   input  logic signed [15:0] req_offset,
   input  logic [19:0] req_abs_address,
   input  logic signed [19:0] req_imm_value,
   input  logic signed [31:0] req_host_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_next_pc,
   output logic signed [31:0] rsp_result_word,
   output logic [1:0]  rsp_cond_code,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_stopped,
   input  logic [12:0] stack_low,
   input  logic [12:0] data_limit,
   input  logic        sp_load,
   input  logic [11:0] sp_value,
   input  logic        pc_load,
   input  logic [19:0] pc_value,
   output smie_pkg::mem_req_type mem_req,
   input  logic [31:0] mem_rd_data
);
   import smie_pkg::*;

   localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   // Register number taken modulo the register count.
   function automatic logic [RW-1:0] reg_sel(input logic [3:0] n);
      logic [4:0] v;
      v = {1'b0, n};
      for (int k = 0; k < 8; k++) begin
         if (v >= 5'(NUM_REGS)) v = v - 5'(NUM_REGS);
      end
      return RW'(v);
   endfunction

   // Stage 1 holds an item whose memory read is in flight.
   logic        s1_valid_ff, s1_valid_in;
   op_type      s1_op_ff;
   logic [RW-1:0] s1_r_ff;
   logic [31:0] s1_rval_ff;
   logic [19:0] s1_wa_ff;
   logic        s1_needw_ff;
   logic        s1_host_ff;

   logic [31:0] regs_ff [NUM_REGS];
   logic [19:0] pc_ff;
   logic [12:0] sp_ff;
   logic [1:0]  cc_ff;
   logic        halt_ff;

   logic        ov_ff;
   logic [19:0] o_pc_ff;
   logic [31:0] o_res_ff;
   logic [1:0]  o_cc_ff;
   logic [2:0]  o_err_ff;
   logic        o_stop_ff;

   logic [12:0] lim;
   assign lim = (DATA_WORDS > 8191 || data_limit < 13'(DATA_WORDS)) ? data_limit
                                                                     : 13'(DATA_WORDS);

   // Output register frees when empty or taken; stage 1 ends into it.
   logic out_free, s1_done, accept;
   assign out_free  = !ov_ff || rsp_ready;
   assign s1_done   = s1_valid_ff && out_free;
   // A following item may not enter while stage 1 waits to finish.
   assign req_ready = out_free && !s1_valid_ff;
   assign accept    = req_valid && req_ready;

   // Decode of the incoming item against current state.
   op_type op;
   logic [RW-1:0] r, ir;
   logic [31:0] rv;
   logic signed [33:0] addr;
   logic [19:0] npc, ea20;
   logic addr_ok, taken, sp_ok, nsp_ok;
   logic [12:0] nsp;

   // State as seen by the incoming item (stage 1 has already retired, since none enters while it waits).
   logic [31:0] fwd_word;
   always_comb begin
      op     = op_type'(req_op);
      r      = reg_sel(req_reg_or_cond);
      ir     = reg_sel(req_index_reg);
      rv     = regs_ff[r];
      addr   = req_indexed_mode ? (34'(signed'(regs_ff[ir])) + 34'(req_offset))
                                : 34'(req_abs_address);
      ea20   = addr[19:0];
      addr_ok = (addr >= 0) && (addr < 34'(lim));
      npc    = pc_ff + 20'd1;
      sp_ok  = sp_ff < lim;
      nsp    = sp_ff + 13'd1;
      nsp_ok = nsp < lim;
      case (req_reg_or_cond)
         BC_ALWAYS: taken = 1'b1;
         BC_EQ:     taken = cc_ff == CC_ZERO;
         BC_NE:     taken = cc_ff != CC_ZERO;
         BC_GT:     taken = cc_ff == CC_POS;
         BC_GE:     taken = cc_ff != CC_NEG;
         BC_LT:     taken = cc_ff == CC_NEG;
         BC_LE:     taken = cc_ff != CC_POS;
         default:   taken = 1'b0;
      endcase
      fwd_word = mem_rd_data;
   end

   // Execute: decide errors, state updates and memory use.
   logic [2:0]  err;
   logic [31:0] res;
   logic        need_rd, need_wr, imm_wr, reg_wr, cc_wr, set_halt;
   logic [19:0] rd_a, wr_a, pc_n;
   logic [31:0] wr_d, reg_d;
   logic [12:0] sp_n;
   logic        fin_now;
   always_comb begin
      err = ERR_NONE; res = '0; need_rd = 1'b0; need_wr = 1'b0; imm_wr = 1'b0;
      reg_wr = 1'b0; cc_wr = 1'b0; set_halt = 1'b0;
      rd_a = ea20; wr_a = ea20; wr_d = rv; reg_d = '0;
      pc_n = npc; sp_n = sp_ff;
      if (op == OP_HWR || op == OP_HRD) begin
         pc_n = pc_ff;
         if ({14'd0, req_abs_address} >= 34'(lim)) err = ERR_DATA;
         else if (op == OP_HWR) begin
            imm_wr = 1'b1; wr_a = req_abs_address; wr_d = req_host_word;
            res = req_host_word;
         end else begin
            need_rd = 1'b1; rd_a = req_abs_address;
         end
      end else if (halt_ff) begin
         pc_n = pc_ff;
      end else begin
         case (op)
            OP_NOP: ;
            OP_ILL: err = ERR_ILL;
            OP_LOAD, OP_ADD, OP_SUB: begin
               if (req_imm_mode) begin
                  reg_d = 32'(req_imm_value);
                  if (op == OP_ADD) reg_d = rv + reg_d;
                  else if (op == OP_SUB) reg_d = rv - reg_d;
                  reg_wr = 1'b1; cc_wr = 1'b1; res = reg_d;
               end else if (!addr_ok) err = ERR_DATA;
               else need_rd = 1'b1;
            end
            OP_STORE: begin
               if (req_imm_mode) err = ERR_IMM;
               else if (!addr_ok) err = ERR_DATA;
               else begin imm_wr = 1'b1; res = rv; end
            end
            OP_BRANCH, OP_CALL: begin
               if (req_imm_mode) err = ERR_IMM;
               else if (req_reg_or_cond > BC_LE) err = ERR_COND;
               else if (taken) begin
                  if (op == OP_CALL) begin
                     if (!sp_ok) err = ERR_DATA;
                     else if (sp_ff < stack_low) err = ERR_STACK;
                     else begin
                        imm_wr = 1'b1; wr_a = 20'(sp_ff); wr_d = 32'(npc);
                        res = 32'(npc); sp_n = sp_ff - 13'd1;
                     end
                  end
                  pc_n = ea20;
               end
            end
            OP_RET: begin
               if (!sp_ok || !nsp_ok) err = ERR_DATA;
               else begin need_rd = 1'b1; rd_a = 20'(nsp); sp_n = nsp; end
            end
            OP_PUSH: begin
               if (!sp_ok) err = ERR_DATA;
               else if (req_imm_mode) begin
                  if (sp_ff < stack_low) err = ERR_STACK;
                  else begin
                     imm_wr = 1'b1; wr_a = 20'(sp_ff); wr_d = 32'(req_imm_value);
                     res = 32'(req_imm_value); sp_n = sp_ff - 13'd1;
                  end
               end else if (!addr_ok) err = ERR_DATA;
               else if (sp_ff < stack_low) err = ERR_STACK;
               else begin
                  need_rd = 1'b1; need_wr = 1'b1; wr_a = 20'(sp_ff);
                  sp_n = sp_ff - 13'd1;
               end
            end
            OP_POP: begin
               if (req_imm_mode) err = ERR_IMM;
               else if (sp_ff < stack_low || !sp_ok) err = ERR_STACK;
               else if (!addr_ok || !nsp_ok) err = ERR_DATA;
               else begin
                  need_rd = 1'b1; rd_a = 20'(nsp); need_wr = 1'b1;
                  wr_a = ea20; sp_n = nsp;
               end
            end
            OP_HALT: set_halt = 1'b1;
            default: err = ERR_UNK;
         endcase
         if (err != ERR_NONE) begin
            set_halt = 1'b1; pc_n = pc_ff; sp_n = sp_ff; res = '0;
            need_rd = 1'b0; need_wr = 1'b0; imm_wr = 1'b0;
            reg_wr = 1'b0; cc_wr = 1'b0;
         end
      end
      fin_now = !need_rd;
   end

   // Memory port: stage-1 write-back has priority, and no read overlaps it.
   always_comb begin
      mem_req = '0;
      if (s1_valid_ff && s1_needw_ff) begin
         mem_req.wr_en   = s1_done;
         mem_req.wr_addr = s1_wa_ff;
         mem_req.wr_data = fwd_word;
      end else if (accept && imm_wr) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = wr_a;
         mem_req.wr_data = wr_d;
      end
      mem_req.rd_en   = accept && need_rd;
      mem_req.rd_addr = rd_a;
   end

   // Stage 1 retires into the output register; a new read waits for that.
   logic [31:0] s1_res;
   logic [31:0] s1_regv;
   logic [1:0]  s1_cc;
   logic [1:0]  s1_cc_out;
   logic [19:0] s1_pc;
   always_comb begin
      s1_regv = fwd_word;
      case (s1_op_ff)
         OP_ADD:  s1_regv = s1_rval_ff + fwd_word;
         OP_SUB:  s1_regv = s1_rval_ff - fwd_word;
         default: s1_regv = fwd_word;
      endcase
      s1_res = (s1_op_ff == OP_RET) ? '0 : s1_regv;
      s1_cc  = s1_regv[31] ? CC_NEG : ((s1_regv == '0) ? CC_ZERO : CC_POS);
      s1_cc_out = (!s1_host_ff && (s1_op_ff inside {OP_LOAD, OP_ADD, OP_SUB})) ? s1_cc
                                                                               : cc_ff;
      s1_pc  = (!s1_host_ff && s1_op_ff == OP_RET) ? fwd_word[19:0] : pc_ff;
   end

   assign s1_valid_in = (accept && need_rd) ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);

   // Item control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         ov_ff       <= 1'b0;
         pc_ff       <= 20'd0;
         sp_ff       <= 13'd4095;
         cc_ff       <= CC_ZERO;
         halt_ff     <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (pc_load) pc_ff <= pc_value;
         if (sp_load) sp_ff <= {1'b0, sp_value};
         if (s1_done) begin
            ov_ff     <= 1'b1;
            o_res_ff  <= s1_res;
            o_cc_ff   <= s1_cc_out;
            o_pc_ff   <= s1_pc;
            o_err_ff  <= ERR_NONE;
            o_stop_ff <= halt_ff;
            if (!s1_host_ff) begin
               case (s1_op_ff)
                  OP_LOAD, OP_ADD, OP_SUB: begin
                     regs_ff[s1_r_ff] <= s1_regv;
                     cc_ff <= s1_cc;
                  end
                  OP_RET: pc_ff <= fwd_word[19:0];
                  default: ;
               endcase
            end
         end else if (accept && fin_now) begin
            ov_ff     <= 1'b1;
            o_res_ff  <= res;
            o_err_ff  <= err;
            o_pc_ff   <= pc_n;
            o_cc_ff   <= cc_wr ? (reg_d[31] ? CC_NEG : ((reg_d == '0) ? CC_ZERO : CC_POS))
                               : cc_ff;
            o_stop_ff <= halt_ff || set_halt;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
         if (accept) begin
            pc_ff <= pc_n;
            sp_ff <= sp_n;
            if (set_halt) halt_ff <= 1'b1;
            if (reg_wr) regs_ff[r] <= reg_d;
            if (cc_wr) cc_ff <= reg_d[31] ? CC_NEG : ((reg_d == '0) ? CC_ZERO : CC_POS);
         end
      end
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      if (accept && need_rd) begin
         s1_op_ff    <= op;
         s1_r_ff     <= r;
         s1_rval_ff  <= rv;
         s1_wa_ff    <= wr_a;
         s1_needw_ff <= need_wr;
         s1_host_ff  <= (op == OP_HRD);
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_next_pc     = o_pc_ff;
   assign rsp_result_word = o_res_ff;
   assign rsp_cond_code   = o_cc_ff;
   assign rsp_error_code  = o_err_ff;
   assign rsp_stopped     = o_stop_ff;
endmodule

@@ hw/rtl/smie_checker.sv @@
`timescale 1ns / 1ps
module smie_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_cond_code,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_stopped,
   input logic [19:0] rsp_next_pc
);
   import smie_pkg::*;

   // A reported error other than a data error always stops the block.
   a_err_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE && rsp_error_code != ERR_DATA
      |-> rsp_stopped) else $error("error without stop");

   // The condition code never shows the unused encoding.
   a_cc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cond_code != 2'd3) else $error("bad condition code");

   // Error codes stay in their range.
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_COND) else $error("bad error code");

   // A stalled result beat stays valid and keeps its next PC.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("result beat changed");
endmodule

bind stack_machine_instruction_execute smie_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_cond_code,
   .rsp_error_code, .rsp_stopped, .rsp_next_pc
);
